// ===== hw/rtl/bdpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpd_pkg
// Shared widths, register map and lane control type for the button debounce
// and press detect block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpd_pkg;

  // Number of debounced buttons; one filter lane per button
  localparam int BUTTON_COUNT = 4;

  // Fixed field widths
  localparam int LEVEL_W = 4;
  localparam int TIME_W  = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // Register map: register i at byte address 4*i
  typedef enum logic [0:0] {
    REG_DEBOUNCE_INTERVAL = 1'b0,
    REG_INITIAL_LEVELS    = 1'b1
  } reg_idx_t;

  // Item modes
  typedef enum logic [0:0] {
    MODE_OBSERVE = 1'b0,
    MODE_RESTART = 1'b1
  } mode_t;

  // Per-item control broadcast to every lane
  typedef struct packed {
    logic step;     // observe item with a non-zero interval
    logic restart;  // reload from the initial levels
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bdpd_in_if.sv =====
// ----------------------------------------------------------------------------
// bdpd_in_if
// Sample channel: valid/ready handshake carrying one button sample item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdpd_in_if
  import bdpd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [LEVEL_W-1:0] sampled_buttons;
  logic [TIME_W-1:0]  time_now;

  modport source (output valid, mode, sampled_buttons, time_now, input ready);
  modport sink   (input valid, mode, sampled_buttons, time_now, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bdpd_out_if.sv =====
// ----------------------------------------------------------------------------
// bdpd_out_if
// Press channel: valid/ready handshake carrying one press mask item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdpd_out_if
  import bdpd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] pressed_buttons;

  modport source (output valid, pressed_buttons, input ready);
  modport sink   (input valid, pressed_buttons, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bdpd_lane.sv =====
// ----------------------------------------------------------------------------
// bdpd_lane
// Debounce filter for one button: stable, candidate, pending and change time.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpd_lane
  import bdpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lane_ctrl_t        ctrl,
  input  wire logic              sample,
  input  wire logic [TIME_W-1:0] time_now,
  input  wire logic [TIME_W-1:0] interval,
  input  wire logic              init_level,
  output logic                   pressed
);

  logic              stable;
  logic              candidate;
  logic              pending;
  logic [TIME_W-1:0] change_time;

  logic              stable_next;
  logic              candidate_next;
  logic              pending_next;
  logic [TIME_W-1:0] change_time_next;
  logic [TIME_W-1:0] elapsed;
  logic              settle;

  // Track the candidate, then commit it once it has held long enough
  always_comb begin
    candidate_next   = candidate;
    change_time_next = change_time;
    pending_next     = pending;
    stable_next      = stable;
    if (sample != candidate) begin
      candidate_next   = sample;
      change_time_next = time_now;
      pending_next     = 1'b1;
    end
    elapsed = time_now - change_time_next;
    settle  = pending_next && (elapsed >= interval);
    if (settle) begin
      stable_next  = candidate_next;
      pending_next = 1'b0;
    end
    pressed = ctrl.step && settle && !stable && candidate_next;
  end

  // Hold filter state; advance on observe items, reload on restart
  always_ff @(posedge clk) begin
    if (rst) begin
      stable      <= 1'b0;
      candidate   <= 1'b0;
      pending     <= 1'b0;
      change_time <= '0;
    end else if (ctrl.restart) begin
      stable      <= init_level;
      candidate   <= init_level;
      pending     <= 1'b0;
      change_time <= '0;
    end else if (ctrl.step) begin
      stable      <= stable_next;
      candidate   <= candidate_next;
      pending     <= pending_next;
      change_time <= change_time_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bdpd_merge.sv =====
// ----------------------------------------------------------------------------
// bdpd_merge
// Gathers the lane press bits into one mask and holds it in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpd_merge
  import bdpd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire logic [BUTTON_COUNT-1:0] lane_pressed,
  output logic                         space,
  bdpd_out_if.source                   presses
);

  logic               valid;
  logic [LEVEL_W-1:0] mask;
  logic [LEVEL_W-1:0] mask_next;

  // Place lane bits in button order, unused bits zero
  always_comb begin
    mask_next = '0;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      mask_next[b] = lane_pressed[b];
    end
  end

  // Room for a new result when empty or when the held one leaves now
  assign space = !valid || presses.ready;

  // Hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (presses.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mask <= mask_next;
    end
  end

  assign presses.valid           = valid;
  assign presses.pressed_buttons = mask;

endmodule

`default_nettype wire

// ===== hw/rtl/button_debounce_press_detect.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_detect
// Debounces a set of buttons against a millisecond timestamp and reports
// buttons that have newly settled in the pressed level.
// ----------------------------------------------------------------------------
// Usage:
//   samples : one item per transfer with mode, sampled_buttons and time_now.
//             Mode observe filters the sample; mode restart reloads every
//             button from initial_levels and yields an empty mask.
//   presses : exactly one pressed_buttons mask per sample item, in order.
//   APB     : debounce_interval at byte 0, initial_levels at byte 4. Write
//             only while idle. An interval of zero turns observe items into
//             no-ops that yield an empty mask.
// Timing: one lane per button updates its state in the cycle the sample is
//   taken; the mask is visible from the next cycle. One item per cycle while
//   the receiver takes each mask, limited by the single output register.
// Stall: the output register holds its mask while the receiver is stalled;
//   samples.ready drops only when a held mask is not taken in that cycle.
// Reset: all button levels, pending flags and both registers clear to zero,
//   and the output register is emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_press_detect
  import bdpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  bdpd_in_if.sink                samples,
  bdpd_out_if.source             presses,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [TIME_W-1:0]       debounce_interval;
  logic [LEVEL_W-1:0]      initial_levels;
  logic                    space;
  logic                    take;
  lane_ctrl_t              ctrl;
  logic [BUTTON_COUNT-1:0] lane_pressed;
  reg_idx_t                reg_sel;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_interval <= '0;
      initial_levels    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_DEBOUNCE_INTERVAL: debounce_interval <= pwdata[TIME_W-1:0];
        REG_INITIAL_LEVELS:    initial_levels    <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEBOUNCE_INTERVAL: prdata = DATA_W'(debounce_interval);
      REG_INITIAL_LEVELS:    prdata = DATA_W'(initial_levels);
      default:               prdata = '0;
    endcase
  end

  // Sample transfer and per-item lane control
  assign samples.ready = space;
  assign take          = samples.valid && space;
  assign ctrl.restart  = take && (mode_t'(samples.mode) == MODE_RESTART);
  assign ctrl.step     = take && (mode_t'(samples.mode) == MODE_OBSERVE)
                         && (debounce_interval != '0);

  // One filter lane per button
  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
    bdpd_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sample     (samples.sampled_buttons[b]),
      .time_now   (samples.time_now),
      .interval   (debounce_interval),
      .init_level (initial_levels[b]),
      .pressed    (lane_pressed[b])
    );
  end

  // Merge lane results into the output register
  bdpd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (take),
    .lane_pressed (lane_pressed),
    .space        (space),
    .presses      (presses)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives button samples with timestamps into the debounce filter, predicts
// each press mask from its own copy of the per-button state and compares
// every mask the block returns, across several interval and restart-level
// settings.
// ----------------------------------------------------------------------------

import bdpd_pkg::*;

// Tracks the filter state and holds the press masks still to arrive
class press_scoreboard;
  logic [TIME_W-1:0]  interval;
  logic [LEVEL_W-1:0] restart_levels;
  logic [LEVEL_W-1:0] stable;
  logic [LEVEL_W-1:0] candidate;
  logic [LEVEL_W-1:0] pending;
  logic [TIME_W-1:0]  change_time [BUTTON_COUNT];
  logic [LEVEL_W-1:0] expected_presses [$];
  int                 errors;

  function new();
    interval       = '0;
    restart_levels = '0;
    errors         = 0;
    reload();
  endfunction

  // Load stable and candidate levels from the restart levels
  function void reload();
    stable    = restart_levels;
    candidate = restart_levels;
    pending   = '0;
    for (int b = 0; b < BUTTON_COUNT; b++) change_time[b] = '0;
  endfunction

  function void set_register(reg_idx_t idx, logic [DATA_W-1:0] value);
    case (idx)
      REG_DEBOUNCE_INTERVAL: interval = value[TIME_W-1:0];
      REG_INITIAL_LEVELS:    restart_levels = value[LEVEL_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the filter by one accepted sample and queue the press mask
  function void note_sample(mode_t mode, logic [LEVEL_W-1:0] sampled,
                            logic [TIME_W-1:0] now);
    logic [LEVEL_W-1:0] pressed;
    logic [TIME_W-1:0]  elapsed;
    pressed = '0;
    if (mode == MODE_RESTART) begin
      reload();
    end else if (interval != '0) begin
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        if (sampled[b] != candidate[b]) begin
          candidate[b]   = sampled[b];
          change_time[b] = now;
          pending[b]     = 1'b1;
        end
        elapsed = now - change_time[b];
        if (pending[b] && elapsed >= interval) begin
          if (!stable[b] && candidate[b]) pressed[b] = 1'b1;
          stable[b]  = candidate[b];
          pending[b] = 1'b0;
        end
      end
    end
    expected_presses.push_back(pressed);
  endfunction

  // Compare a returned mask with the oldest one waiting
  function void check_press(logic [LEVEL_W-1:0] got);
    logic [LEVEL_W-1:0] want;
    if (expected_presses.size() == 0) begin
      errors++;
      $display("%0t: pressed_buttons %h arrived with nothing expected", $time, got);
      return;
    end
    want = expected_presses.pop_front();
    if (got !== want) begin
      errors++;
      $display("%0t: pressed_buttons expected %h, actual %h", $time, want, got);
    end
  endfunction
endclass

module testbench;

  localparam int CLK_PERIOD     = 10;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLD_OFF       = 150;
  localparam int WATCHDOG_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bdpd_in_if  samples_if ();
  bdpd_out_if presses_if ();

  press_scoreboard sb = new();

  bit idling_on        = 1'b1;
  bit hold_off_request = 1'b0;
  int stall_left       = 0;
  int quiet_cycles     = 0;

  button_debounce_press_detect dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .presses (presses_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offer one sample, after an optional gap, and hold it until the transfer
  task automatic send_sample(input mode_t mode, input logic [LEVEL_W-1:0] sampled,
                             input logic [TIME_W-1:0] now);
    int gap;
    gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_if.valid           <= 1'b1;
    samples_if.mode            <= mode;
    samples_if.sampled_buttons <= sampled;
    samples_if.time_now        <= now;
    do @(posedge clk); while (!samples_if.ready);
    sb.note_sample(mode, sampled, now);
  endtask

  // Drop valid and wait until every press mask has come back
  task automatic drain_presses();
    @(negedge clk);
    samples_if.valid <= 1'b0;
    while (sb.expected_presses.size() != 0) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase
  task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reconfigure once the block has gone quiet
  task automatic configure(input logic [TIME_W-1:0] interval,
                           input logic [DATA_W-1:0] levels);
    drain_presses();
    repeat (2) @(posedge clk);
    write_register(REG_DEBOUNCE_INTERVAL, interval);
    write_register(REG_INITIAL_LEVELS, levels);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  always begin
    @(negedge clk);
    if (stall_left > 0) begin
      presses_if.ready <= 1'b0;
      stall_left--;
    end else if (hold_off_request) begin
      presses_if.ready <= 1'b0;
      stall_left = HOLD_OFF - 1;
      hold_off_request = 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      presses_if.ready <= 1'b0;
      stall_left = $urandom_range(1, 13) - 1;
    end else begin
      presses_if.ready <= 1'b1;
    end
  end

  // Check each returned mask
  always @(posedge clk) begin
    if (!rst && presses_if.valid && presses_if.ready)
      sb.check_press(presses_if.pressed_buttons);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) ||
        (presses_if.valid && presses_if.ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("button_debounce_press_detect: mismatch");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0]  clock_ms;
    logic [TIME_W-1:0]  step_max;
    logic [TIME_W-1:0]  interval;
    logic [DATA_W-1:0]  levels;
    logic [LEVEL_W-1:0] held;
    logic [LEVEL_W-1:0] sampled;

    rst                        = 1'b1;
    psel                       = 1'b0;
    penable                    = 1'b0;
    pwrite                     = 1'b0;
    paddr                      = '0;
    pwdata                     = '0;
    samples_if.valid           = 1'b0;
    samples_if.mode            = MODE_OBSERVE;
    samples_if.sampled_buttons = '0;
    samples_if.time_now        = '0;
    presses_if.ready           = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Interval zero after reset: observe is a no-op, restart still reloads
    send_sample(MODE_OBSERVE, 4'hF, 32'd100);
    send_sample(MODE_RESTART, 4'hF, 32'hFFFF_FFFF);

    // Bounce, settle, release and a press across the time wrap
    configure(32'd10, 32'h0);
    send_sample(MODE_OBSERVE, 4'h1, 32'd1000);
    send_sample(MODE_OBSERVE, 4'h0, 32'd1003);
    send_sample(MODE_OBSERVE, 4'h1, 32'd1005);
    send_sample(MODE_OBSERVE, 4'h1, 32'd1014);
    send_sample(MODE_OBSERVE, 4'h1, 32'd1015);
    send_sample(MODE_OBSERVE, 4'hF, 32'd1015);
    send_sample(MODE_OBSERVE, 4'hF, 32'd1025);
    send_sample(MODE_OBSERVE, 4'h0, 32'd1030);
    send_sample(MODE_OBSERVE, 4'h0, 32'd1040);
    send_sample(MODE_OBSERVE, 4'h5, 32'hFFFF_FFFA);
    send_sample(MODE_OBSERVE, 4'h5, 32'h0000_0004);
    send_sample(MODE_OBSERVE, 4'hA, 32'h8000_0000);
    send_sample(MODE_OBSERVE, 4'hA, 32'h8000_000A);

    // Largest interval: only an elapsed time of all ones settles
    configure(32'hFFFF_FFFF, 32'hF);
    send_sample(MODE_RESTART, 4'h0, 32'h0);
    send_sample(MODE_OBSERVE, 4'h0, 32'h1234_5678);
    send_sample(MODE_OBSERVE, 4'h0, 32'h1234_5677);
    send_sample(MODE_OBSERVE, 4'h3, 32'hFFFF_FFFF);
    send_sample(MODE_OBSERVE, 4'h3, 32'hFFFF_FFFE);

    // Smallest interval; upper bits of the levels write are dropped
    configure(32'd1, 32'hFFFF_FFFA);
    send_sample(MODE_RESTART, 4'hF, 32'hFFFF_FFFF);
    send_sample(MODE_OBSERVE, 4'h5, 32'd7);
    send_sample(MODE_OBSERVE, 4'h5, 32'd8);
    send_sample(MODE_OBSERVE, 4'h5, 32'd8);

    // Random phases: held patterns with bounce, steady time, some noise
    clock_ms = $urandom;
    held     = '0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       interval = 32'd1;
        1:       interval = 32'hFFFF_FFFF;
        2:       interval = 32'd0;
        3:       interval = $urandom;
        4:       interval = $urandom_range(2, 1000);
        default: interval = $urandom_range(2, 40);
      endcase
      case (phase % 3)
        0:       levels = 32'h0;
        1:       levels = 32'hF;
        default: levels = $urandom;
      endcase
      configure(interval, levels);
      if (phase == PHASES - 1) idling_on = 1'b0;
      step_max = (interval > 32'd3) ? interval / 3 : 32'd1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == PHASE_ITEMS / 2) hold_off_request = 1'b1;
        if (phase == 7 && n == PHASE_ITEMS / 2) drain_presses();
        if ($urandom_range(0, 39) == 0) begin
          send_sample(MODE_RESTART, LEVEL_W'($urandom_range(0, 15)), $urandom);
        end else begin
          if ($urandom_range(0, 11) == 0) held = LEVEL_W'($urandom_range(0, 15));
          sampled = held;
          if ($urandom_range(0, 3) == 0) sampled[$urandom_range(0, 3)] ^= 1'b1;
          if ($urandom_range(0, 19) == 0)
            clock_ms = $urandom;
          else
            clock_ms = clock_ms + $urandom_range(0, step_max);
          send_sample(MODE_OBSERVE, sampled, clock_ms);
        end
      end
    end

    // Let the last masks arrive, then a short settle
    drain_presses();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_presses.size() == 0)
      $display("button_debounce_press_detect: match");
    else
      $display("button_debounce_press_detect: mismatch");
    $finish;
  end

endmodule
